### sv/pbr_pkg.sv
// Package: types and constants for the projected bounding rectangle block.
`timescale 1ns / 1ps
package pbr_pkg;

  localparam int unsigned CoefW = 16;
  localparam int unsigned ClipW = 40;
  localparam int unsigned NormW = 32;
  localparam int unsigned SizeW = 14;
  localparam int unsigned QuotW = 48;

  typedef enum logic [2:0] {
    CFG_ROW_X  = 3'd0,
    CFG_ROW_Y  = 3'd1,
    CFG_ROW_W  = 3'd2,
    CFG_VIEW_W = 3'd3,
    CFG_VIEW_H = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAC,
    ST_CHECK,
    ST_DIV_X,
    ST_DIV_Y,
    ST_UPDATE,
    ST_PIX,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic               last_vertex;
  } vtx_t;

  typedef struct packed {
    logic signed [15:0] rect_left;
    logic signed [15:0] rect_top;
    logic signed [15:0] rect_width;
    logic signed [15:0] rect_height;
    logic               behind_camera;
  } rect_t;

  // Divider control and status.
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  function automatic logic signed [NormW-1:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'sh8000_0000;
    return v[NormW-1:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
    if (v > 48'sd32767) return 16'sh7FFF;
    if (v < -48'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

endpackage

### sv/pbr_div.sv
// Radix-2 restoring divider, one quotient bit a cycle, signed, truncating.
`timescale 1ns / 1ps
module pbr_div
  import pbr_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  div_ctl_t                ctl_i,
  input  logic signed [63:0]      num_i,
  input  logic        [ClipW-1:0] den_i,   // positive
  output div_sts_t                sts_o,
  output logic signed [63:0]      quo_o
);

  localparam int unsigned CntW = 6;

  logic [63:0]      mag_q, mag_d;
  logic [ClipW:0]   rem_q, rem_d;
  logic [ClipW-1:0] den_q, den_d;
  logic             neg_q, neg_d;
  logic [CntW:0]    cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [ClipW:0]   trial;

  always_comb begin
    mag_d  = mag_q;
    rem_d  = rem_q;
    den_d  = den_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = '0;
    if (ctl_i.start) begin
      mag_d  = num_i[63] ? 64'(-num_i) : 64'(num_i);
      neg_d  = num_i[63];
      den_d  = den_i;
      rem_d  = '0;
      cnt_d  = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q[ClipW-1:0], mag_q[63]};
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        mag_d = {mag_q[62:0], 1'b1};
      end else begin
        rem_d = trial;
        mag_d = {mag_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quo_o      = neg_q ? -$signed(mag_q) : $signed(mag_q);

endmodule

### sv/projected_bounding_rectangle_core.sv
// Top level: projected bounding rectangle of a vertex stream.
`timescale 1ns / 1ps
// Each vertex word is transformed by the x, y and w matrix rows on one
// shared multiplier, one coefficient product per cycle. Then cx/cw and
// -cy/cw are formed by a shared bit-serial divider. A vertex with w <= 0
// skips the divides. On a word marked last, the four pixel terms are
// scaled by the viewport size in a narrow 34x15 multiplier. The result
// word is loaded into an output register in ST_OUT once that register is
// free, so the next mesh starts while it waits. in_ready_o is low while a
// vertex is in flight. A second result stalls the block until the first
// one has left.
// Configuration must be written only while idle.
module projected_bounding_rectangle_core
  import pbr_pkg::*;
#(
  parameter int unsigned POS_FRAC_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  vtx_t        in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output rect_t       out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  // Configuration registers.
  logic [63:0]      row_q [3];
  logic [SizeW-1:0] vw_q, vh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0] <= 64'd1024;
      row_q[1] <= 64'd1024 << 16;
      row_q[2] <= 64'd1024 << 48;
      vw_q     <= 14'd640;
      vh_q     <= 14'd480;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_ROW_X:  row_q[0] <= cfg_data_i;
        CFG_ROW_Y:  row_q[1] <= cfg_data_i;
        CFG_ROW_W:  row_q[2] <= cfg_data_i;
        CFG_VIEW_W: vw_q     <= cfg_data_i[SizeW-1:0];
        CFG_VIEW_H: vh_q     <= cfg_data_i[SizeW-1:0];
        default: ;
      endcase
    end
  end
  assign cfg_ready_o = 1'b1;

  state_e state_q, state_d;
  vtx_t   vtx_q;
  logic [3:0] step_q, step_d;
  logic signed [63:0] acc_q [3];
  logic signed [NormW-1:0] nx_q, ny_q;
  logic signed [NormW-1:0] xl_q, xg_q, yl_q, yg_q;
  logic   skip_q;
  rect_t  res_q;
  logic   out_valid_q;
  logic   res_load;  // output register free: take the finished word
  logic signed [47:0] pix_q [4];

  // Shared multiplier.
  logic signed [16:0] mul_a;
  logic signed [18:0] mul_b;
  logic signed [35:0] mul_p;
  logic [1:0] row_sel, col_sel;

  div_ctl_t div_ctl;
  div_sts_t div_sts;
  logic signed [63:0] div_num, div_quo;

  pbr_div u_div (
    .clk_i, .rst_ni, .ctl_i(div_ctl), .num_i(div_num),
    .den_i(acc_q[2][ClipW-1:0]), .sts_o(div_sts), .quo_o(div_quo)
  );

  localparam logic signed [16:0] One = 17'sd1 <<< POS_FRAC_BITS;

  always_comb begin
    row_sel = step_q[3:2] == 2'd3 ? 2'd2 : step_q[3:2];
    col_sel = step_q[1:0];
    mul_a = '0;
    mul_b = '0;
    if (state_q == ST_MAC) begin
      mul_a = 17'($signed(row_q[row_sel][16*col_sel +: 16]));
      case (col_sel)
        2'd0:    mul_b = 19'(vtx_q.pos_x);
        2'd1:    mul_b = 19'(vtx_q.pos_y);
        2'd2:    mul_b = 19'(vtx_q.pos_z);
        default: mul_b = 19'(One);
      endcase
    end else begin
      // Pixel terms: (n + 65536) or difference, by viewport size.
      case (step_q[1:0])
        2'd0:    mul_a = {3'b0, vw_q};
        2'd1:    mul_a = {3'b0, vh_q};
        2'd2:    mul_a = {3'b0, vw_q};
        default: mul_a = {3'b0, vh_q};
      endcase
    end
    mul_p = mul_a * mul_b;
  end

  // Pixel multiply is 34-bit by 14-bit; done as a separate product.
  logic signed [33:0] pix_a;
  logic signed [47:0] pix_p;
  always_comb begin
    case (step_q[1:0])
      2'd0:    pix_a = 34'(xl_q) + 34'sd65536;
      2'd1:    pix_a = 34'(yl_q) + 34'sd65536;
      2'd2:    pix_a = 34'(xg_q) - 34'(xl_q);
      default: pix_a = 34'(yg_q) - 34'(yl_q);
    endcase
    pix_p = pix_a * $signed({1'b0, mul_a[SizeW-1:0]});
  end

  assign res_load = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  // Next state.
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i && in_ready_o) begin
                   state_d = ST_MAC;
                   step_d  = '0;
                 end
      ST_MAC: begin
        step_d = step_q + 4'd1;
        if (step_q == 4'd11) state_d = ST_CHECK;
      end
      ST_CHECK:  state_d = (acc_q[2] <= 0) ? ST_UPDATE : ST_DIV_X;
      ST_DIV_X:  if (div_sts.done) state_d = ST_DIV_Y;
      ST_DIV_Y:  if (div_sts.done) state_d = ST_UPDATE;
      ST_UPDATE: begin
        step_d  = '0;
        state_d = vtx_q.last_vertex ? ST_PIX : ST_IDLE;
      end
      ST_PIX: begin
        step_d = step_q + 4'd1;
        if (step_q == 4'd3) state_d = ST_OUT;
      end
      ST_OUT:    if (res_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready_o  = state_q == ST_IDLE;
    out_valid_o = out_valid_q;
    div_ctl.start = 1'b0;
    div_num = '0;
    if (state_q == ST_CHECK && acc_q[2] > 0) begin
      div_ctl.start = 1'b1;
      div_num = acc_q[0] <<< 16;
    end else if (state_q == ST_DIV_X && div_sts.done) begin
      div_ctl.start = 1'b1;
      div_num = -(acc_q[1] <<< 16);
    end
  end
  assign out_data_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      xl_q <= 32'sh7FFF_FFFF; yl_q <= 32'sh7FFF_FFFF;
      xg_q <= 32'sh8000_0000; yg_q <= 32'sh8000_0000;
      skip_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (state_q == ST_CHECK && acc_q[2] <= 0) skip_q <= 1'b1;
      if (state_q == ST_UPDATE && acc_q[2] > 0) begin
        if (nx_q < xl_q) xl_q <= nx_q;
        if (nx_q > xg_q) xg_q <= nx_q;
        if (ny_q < yl_q) yl_q <= ny_q;
        if (ny_q > yg_q) yg_q <= ny_q;
      end
      if (res_load) begin
        xl_q <= 32'sh7FFF_FFFF; yl_q <= 32'sh7FFF_FFFF;
        xg_q <= 32'sh8000_0000; yg_q <= 32'sh8000_0000;
        skip_q <= 1'b0;
      end
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      vtx_q <= in_data_i;
      acc_q[0] <= '0; acc_q[1] <= '0; acc_q[2] <= '0;
    end
    if (state_q == ST_MAC) acc_q[row_sel] <= acc_q[row_sel] + 64'(mul_p);
    if (state_q == ST_DIV_X && div_sts.done) nx_q <= sat32(div_quo);
    if (state_q == ST_DIV_Y && div_sts.done) ny_q <= sat32(div_quo);
    if (state_q == ST_PIX) begin
      // Truncating divide by 2^17 toward zero.
      pix_q[step_q[1:0]] <= (pix_p < 0) ? -((-pix_p) >>> 17) : (pix_p >>> 17);
    end
    if (res_load) begin
      res_q.rect_left     <= sat16(pix_q[0]);
      res_q.rect_top      <= sat16(pix_q[1]);
      res_q.rect_width    <= sat16(pix_q[2]);
      res_q.rect_height   <= sat16(pix_q[3]);
      res_q.behind_camera <= skip_q;
    end
  end

endmodule
